### src/bba_pkg.sv
`default_nettype none
package bba_pkg;

  localparam int POOL_BLOCKS_DEF = 256;
  localparam int CFG_W           = 9;
  localparam int RESET_BLOCKS    = 256;

  // one cell holds one word of the bitmap
  localparam int WORD_BITS = 32;
  localparam int WORD_LOG  = 5;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OUT_OF_BLOCKS = 2'd1,
    ST_INVALID_INDEX = 2'd2,
    ST_ALREADY_FREE  = 2'd3
  } status_t;

  // request travelling down the row of cells
  typedef struct packed {
    logic       valid;
    logic       cmd;
    logic [7:0] idx;
    logic       done;
    status_t    status;
    logic [7:0] granted;
  } token_t;

endpackage
`default_nettype wire

### src/bba_in_if.sv
`default_nettype none
interface bba_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] block_index;

  modport source (output valid, output command, output block_index, input ready);
  modport sink   (input valid, input command, input block_index, output ready);
endinterface
`default_nettype wire

### src/bba_out_if.sv
`default_nettype none
interface bba_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] granted_block;
  logic [8:0] free_blocks;

  modport source (output valid, output status, output granted_block, output free_blocks,
                  input ready);
  modport sink   (input valid, input status, input granted_block, input free_blocks,
                  output ready);
endinterface
`default_nettype wire

### src/bba_cell.sv
`default_nettype none
module bba_cell
  import bba_pkg::*;
#(
  parameter int CELL_ID = 0,
  parameter int SZW     = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           clear,
  input  logic [SZW-1:0] size,
  input  token_t         tok_in,
  output token_t         tok_out
);

  localparam int Base = CELL_ID * WORD_BITS;

  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [WORD_BITS-1:0] avail, lowest;
  logic [WORD_LOG-1:0]  pos;
  logic [WORD_LOG-1:0]  sel;
  logic                 hit;
  token_t               tok_r, tok_nxt;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      avail[j] = !word_r[j] && ((Base + j) < int'(size));
    end
    // isolate lowest free bit, then encode it
    lowest = avail & (~avail + 1'b1);
    pos = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (lowest[j]) begin
        pos = pos | WORD_LOG'(j);
      end
    end
    hit = (int'(tok_in.idx >> WORD_LOG) == CELL_ID);
    sel = tok_in.idx[WORD_LOG-1:0];

    word_nxt = word_r;
    tok_nxt  = tok_in;
    if (tok_in.valid && !tok_in.done) begin
      if (tok_in.cmd == CMD_ALLOC) begin
        if (|avail) begin
          word_nxt        = word_r | lowest;
          tok_nxt.done    = 1'b1;
          tok_nxt.status  = ST_OK;
          tok_nxt.granted = 8'(Base + int'(pos));
        end
      end else if (hit) begin
        tok_nxt.done = 1'b1;
        if (word_r[sel]) begin
          word_nxt[sel]  = 1'b0;
          tok_nxt.status = ST_OK;
        end else begin
          tok_nxt.status = ST_ALREADY_FREE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

### src/bitmap_block_allocator.sv
`default_nettype none
// channel   dir  word
// in_ch     in   command, block_index
// out_ch    out  status, granted_block, free_blocks
// cfg_*     in   pool size, clears the pool (write only)
//
// a request walks the row of bitmap cells, one 32-block cell per cycle, then
// passes the pending register and the output register, where it may wait on
// out_ch.ready.
// one request in flight at a time; the next is taken once its result is in
// the output register, even while that result is still waiting.
// reset frees every block and sets the pool size to 256 (saturated).
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bba_in_if.sink           in_ch,
  bba_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int SZW       = $clog2(POOL_BLOCKS + 1);
  localparam int CW        = (SZW > CFG_W) ? SZW : CFG_W;
  localparam int NCELLS    = (POOL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ResetSize = (RESET_BLOCKS > POOL_BLOCKS) ? POOL_BLOCKS : RESET_BLOCKS;

  logic [SZW-1:0] size_r, free_cnt_r, free_cnt_nxt, cfg_size;
  logic [CW-1:0]  cfg_ext;
  logic           busy_r, pend_valid_r, out_valid_r;
  logic           accept, move;
  token_t         chain [NCELLS+1];
  token_t         entry, tail;
  status_t        res_status;
  status_t        pend_status_r, out_status_r;
  logic [7:0]     pend_granted_r, out_granted_r;
  logic [8:0]     pend_free_r, out_free_r;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy_r;

  assign cfg_ext  = CW'(cfg_data);
  assign cfg_size = (cfg_ext > CW'(POOL_BLOCKS)) ? SZW'(POOL_BLOCKS) : SZW'(cfg_ext);

  always_comb begin
    entry         = '0;
    entry.valid   = accept;
    entry.cmd     = in_ch.command;
    entry.idx     = in_ch.block_index;
    entry.status  = ST_OK;
    // out-of-range free is settled before the cells
    if (in_ch.command == CMD_FREE && int'(in_ch.block_index) >= int'(size_r)) begin
      entry.done   = 1'b1;
      entry.status = ST_INVALID_INDEX;
    end
  end

  assign chain[0] = entry;

  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    bba_cell #(
      .CELL_ID (g),
      .SZW     (SZW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clear   (cfg_we),
      .size    (size_r),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  assign tail = chain[NCELLS];

  always_comb begin
    res_status   = tail.done ? tail.status : ST_OUT_OF_BLOCKS;
    free_cnt_nxt = free_cnt_r;
    if (res_status == ST_OK) begin
      if (tail.cmd == CMD_ALLOC) begin
        free_cnt_nxt = free_cnt_r - 1'b1;
      end else begin
        free_cnt_nxt = free_cnt_r + 1'b1;
      end
    end
  end

  assign move = pend_valid_r && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r       <= SZW'(ResetSize);
      free_cnt_r   <= SZW'(ResetSize);
      busy_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_r     <= cfg_size;
        free_cnt_r <= cfg_size;
      end else if (tail.valid) begin
        free_cnt_r <= free_cnt_nxt;
      end

      if (accept) begin
        busy_r <= 1'b1;
      end else if (move) begin
        busy_r <= 1'b0;
      end

      if (tail.valid) begin
        pend_valid_r <= 1'b1;
      end else if (move) begin
        pend_valid_r <= 1'b0;
      end

      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (tail.valid) begin
      pend_status_r  <= res_status;
      pend_granted_r <= (res_status == ST_OK && tail.cmd == CMD_ALLOC) ? tail.granted : 8'd0;
      pend_free_r    <= 9'(free_cnt_nxt);
    end
    if (move) begin
      out_status_r  <= pend_status_r;
      out_granted_r <= pend_granted_r;
      out_free_r    <= pend_free_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.granted_block = out_granted_r;
  assign out_ch.free_blocks   = out_free_r;

endmodule
`default_nettype wire
